// ----- rtl/qwkp_pkg.sv -----
package qwkp_pkg;

  // queue geometry
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned HEAD_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  // field widths
  localparam int unsigned KIND_W  = 8;
  localparam int unsigned DUR_W   = 32;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned TOTAL_W = 36;
  localparam int unsigned ENTRY_W = KIND_W + DUR_W + PAY_W;

  // accumulator wide enough for a full queue of durations
  localparam int unsigned ACC_W   = (DUR_W + CNT_W > TOTAL_W) ? DUR_W + CNT_W : TOTAL_W;

  // saturation limits of the promote total
  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 36'sh7_FFFF_FFF0;
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = 36'sh8_0000_0000;

  typedef enum logic [2:0] {
    OP_ENQ     = 3'd0,
    OP_DEQ     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_PROMOTE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_MATCH,
    S_OTHER,
    S_COPY,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [DUR_W-1:0] duration;
    logic [PAY_W-1:0]        payload;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic add;
  } acc_ctl_t;

  // slot of the entry at a given offset from the head
  function automatic logic [HEAD_W-1:0] ring_pos(input logic [HEAD_W-1:0] head,
                                                 input logic [HEAD_W-1:0] off);
    logic [HEAD_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (HEAD_W+1)'(DEPTH)) begin
      sum = sum - (HEAD_W+1)'(DEPTH);
    end
    return sum[HEAD_W-1:0];
  endfunction

endpackage

// ----- rtl/queue_with_kind_promote_unit.sv -----
// channel | valid      | stall       | payload
// --------+------------+-------------+------------------------------------------------
// in      | in_valid_i | in_stall_o  | op_i, kind_i, duration_i, payload_i
// out     | out_valid_o| out_stall_i | status_o, out_kind_o, out_duration_o,
//         |            |             | out_payload_o, total_o
//
// enqueue, clear and unused ops: result registered at the accept edge.
// dequeue and peek: a registered read of the entry memory, then the result is registered;
//   on an empty queue the result is registered at the accept edge.
// promote: three walks over the queue through the single read port of each memory
//   (match pass, other pass, copy back), one entry a cycle, each walk closed by a read
//   drain step and an end step, then a done state that registers the total.
// reset clears head, fill count, sequencer and output valid; no memory clearing pass.
// in_stall_o is high while an op runs and while a held result is stalled.
module queue_with_kind_promote_unit
  import qwkp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                op_i,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic signed [DUR_W-1:0]   duration_i,
  input  logic [PAY_W-1:0]          payload_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [KIND_W-1:0]         out_kind_o,
  output logic signed [DUR_W-1:0]   out_duration_o,
  output logic [PAY_W-1:0]          out_payload_o,
  output logic signed [TOTAL_W-1:0] total_o
);

  state_e                    state_q, state_d;
  logic [HEAD_W-1:0]         head_q, head_d;
  logic [CNT_W-1:0]          fill_q, fill_d;
  logic [CNT_W-1:0]          idx_q, idx_d;
  logic [CNT_W-1:0]          wr_cnt_q, wr_cnt_d;
  logic                      rd_vld_q, rd_vld_d;
  logic [HEAD_W-1:0]         rd_idx_q, rd_idx_d;
  logic                      deq_q, deq_d;
  logic [KIND_W-1:0]         key_q, key_d;

  logic                      out_valid_q, out_valid_d;
  status_e                   status_q, status_d;
  logic [KIND_W-1:0]         out_kind_q, out_kind_d;
  logic signed [DUR_W-1:0]   out_duration_q, out_duration_d;
  logic [PAY_W-1:0]          out_payload_q, out_payload_d;
  logic signed [TOTAL_W-1:0] total_q, total_d;
  logic                      load;

  logic                      accept;
  logic                      issue;
  logic                      pass_end;

  logic                      ent_we;
  logic [HEAD_W-1:0]         ent_waddr, ent_raddr;
  entry_t                    ent_wdata, ent_rdata;
  logic                      scr_we;
  logic [HEAD_W-1:0]         scr_waddr, scr_raddr;
  entry_t                    scr_wdata, scr_rdata;

  acc_ctl_t                  acc_ctl;
  logic signed [TOTAL_W-1:0] acc_total;

  // handshake
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // walk control shared by the three promote passes
  assign issue    = (idx_q != fill_q);
  assign pass_end = (idx_q == fill_q) && !rd_vld_q;

  // entry ring and promote scratch
  qwkp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  qwkp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_scratch_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  // shared adder with saturation
  qwkp_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (acc_ctl),
    .addend_i (ent_rdata.duration),
    .total_o  (acc_total)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_DEQ, OP_PEEK: begin
              if (fill_q != '0) begin
                state_d = S_HEAD;
              end
            end
            OP_PROMOTE: state_d = S_MATCH;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_HEAD:  state_d = S_IDLE;
      S_MATCH: if (pass_end) state_d = S_OTHER;
      S_OTHER: if (pass_end) state_d = S_COPY;
      S_COPY:  if (pass_end) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    head_d         = head_q;
    fill_d         = fill_q;
    idx_d          = idx_q;
    wr_cnt_d       = wr_cnt_q;
    rd_vld_d       = 1'b0;
    rd_idx_d       = rd_idx_q;
    deq_d          = deq_q;
    key_d          = key_q;

    ent_raddr      = ring_pos(head_q, idx_q[HEAD_W-1:0]);
    ent_we         = 1'b0;
    ent_waddr      = ring_pos(head_q, rd_idx_q);
    ent_wdata      = scr_rdata;
    scr_raddr      = idx_q[HEAD_W-1:0];
    scr_we         = 1'b0;
    scr_waddr      = wr_cnt_q[HEAD_W-1:0];
    scr_wdata      = ent_rdata;
    acc_ctl        = '0;

    load           = 1'b0;
    status_d       = STAT_OK;
    out_kind_d     = '0;
    out_duration_d = '0;
    out_payload_d  = '0;
    total_d        = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_ENQ: begin
              load = 1'b1;
              if (fill_q == CNT_W'(DEPTH)) begin
                status_d = STAT_FULL;
              end else begin
                ent_we    = 1'b1;
                ent_waddr = ring_pos(head_q, fill_q[HEAD_W-1:0]);
                ent_wdata = '{kind: kind_i, duration: duration_i, payload: payload_i};
                fill_d    = fill_q + CNT_W'(1);
              end
            end
            OP_DEQ, OP_PEEK: begin
              deq_d = (op_i == OP_DEQ);
              if (fill_q == '0) begin
                load     = 1'b1;
                status_d = STAT_EMPTY;
              end
            end
            OP_CLEAR: begin
              load   = 1'b1;
              head_d = '0;
              fill_d = '0;
            end
            OP_PROMOTE: begin
              key_d       = kind_i;
              acc_ctl.clr = 1'b1;
              idx_d       = '0;
              wr_cnt_d    = '0;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end

      // head entry read out
      S_HEAD: begin
        load           = 1'b1;
        out_kind_d     = ent_rdata.kind;
        out_duration_d = ent_rdata.duration;
        out_payload_d  = ent_rdata.payload;
        if (deq_q) begin
          head_d = ring_pos(head_q, HEAD_W'(1));
          fill_d = fill_q - CNT_W'(1);
        end
      end

      S_MATCH, S_OTHER, S_COPY: begin
        // read side of the walk
        if (issue) begin
          idx_d    = idx_q + CNT_W'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q[HEAD_W-1:0];
        end
        if (pass_end) begin
          idx_d = '0;
        end
        // data side of the walk
        if (rd_vld_q) begin
          case (state_q)
            S_MATCH: begin
              if (ent_rdata.kind == key_q) begin
                scr_we      = 1'b1;
                wr_cnt_d    = wr_cnt_q + CNT_W'(1);
                acc_ctl.add = 1'b1;
              end
            end
            S_OTHER: begin
              if (ent_rdata.kind != key_q) begin
                scr_we   = 1'b1;
                wr_cnt_d = wr_cnt_q + CNT_W'(1);
              end
            end
            default: begin
              ent_we = 1'b1;
            end
          endcase
        end
      end

      S_DONE: begin
        load    = 1'b1;
        total_d = acc_total;
      end

      default: begin
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      wr_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      deq_q       <= 1'b0;
      key_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      wr_cnt_q    <= wr_cnt_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      deq_q       <= deq_d;
      key_q       <= key_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q       <= status_d;
      out_kind_q     <= out_kind_d;
      out_duration_q <= out_duration_d;
      out_payload_q  <= out_payload_d;
      total_q        <= total_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_kind_o     = out_kind_q;
  assign out_duration_o = out_duration_q;
  assign out_payload_o  = out_payload_q;
  assign total_o        = total_q;

endmodule

// ----- rtl/qwkp_ram.sv -----
module qwkp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/qwkp_acc.sv -----
module qwkp_acc
  import qwkp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  acc_ctl_t                  ctl_i,
  input  logic signed [DUR_W-1:0]   addend_i,
  output logic signed [TOTAL_W-1:0] total_o
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(TOTAL_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(TOTAL_MIN);

  logic signed [ACC_W-1:0] acc_q, acc_d;

  // running sum of matching durations
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (ctl_i.add) begin
      acc_d = acc_q + ACC_W'(addend_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // clamp to the result range
  always_comb begin
    if (acc_q > ACC_MAX) begin
      total_o = TOTAL_MAX;
    end else if (acc_q < ACC_MIN) begin
      total_o = TOTAL_MIN;
    end else begin
      total_o = acc_q[TOTAL_W-1:0];
    end
  end

endmodule

// ----- tb/queue_with_kind_promote_unit_tb.sv -----
`timescale 1ns / 1ps

module queue_with_kind_promote_unit_tb;
  import qwkp_pkg::*;

  // op codes the block ignores
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    status_e                    status;
    logic [KIND_W-1:0]          kind;
    logic signed [DUR_W-1:0]    duration;
    logic [PAY_W-1:0]           payload;
    logic signed [TOTAL_W-1:0]  total;
  } queue_result_t;

  typedef struct {
    logic [2:0]                 op;
    logic [KIND_W-1:0]          kind;
    logic signed [DUR_W-1:0]    dur;
    logic [PAY_W-1:0]           pay;
    int                         reps;
    bit                         typed;
    status_e                    exp_status;
    logic signed [TOTAL_W-1:0]  exp_total;
  } dir_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [2:0]                op_i;
  logic [KIND_W-1:0]         kind_i;
  logic signed [DUR_W-1:0]   duration_i;
  logic [PAY_W-1:0]          payload_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [1:0]                status_o;
  logic [KIND_W-1:0]         out_kind_o;
  logic signed [DUR_W-1:0]   out_duration_o;
  logic [PAY_W-1:0]          out_payload_o;
  logic signed [TOTAL_W-1:0] total_o;

  // shadow copy of the queued entries, oldest first
  entry_t        queue_shadow[$];
  queue_result_t pending_results[$];
  queue_result_t blank_res;
  dir_row_t      dir_rows[$];
  logic [KIND_W-1:0] kind_pool[4];
  int            err_count;
  int            rand_items;
  int            burst_left;

  queue_with_kind_promote_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .kind_i         (kind_i),
    .duration_i     (duration_i),
    .payload_i      (payload_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_kind_o     (out_kind_o),
    .out_duration_o (out_duration_o),
    .out_payload_o  (out_payload_o),
    .total_o        (total_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // apply one op to the shadow queue and return what the block should answer
  function automatic queue_result_t apply_queue_op(input logic [2:0] op,
                                                   input logic [KIND_W-1:0] kind,
                                                   input logic signed [DUR_W-1:0] dur,
                                                   input logic [PAY_W-1:0] pay);
    queue_result_t r;
    entry_t        e;
    entry_t        match_q[$];
    entry_t        other_q[$];
    longint        sum;
    r.status   = STAT_OK;
    r.kind     = '0;
    r.duration = '0;
    r.payload  = '0;
    r.total    = '0;
    sum        = 0;
    case (op)
      OP_ENQ: begin
        if (queue_shadow.size() >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          e.kind     = kind;
          e.duration = dur;
          e.payload  = pay;
          queue_shadow.push_back(e);
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (queue_shadow.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          e          = queue_shadow[0];
          r.kind     = e.kind;
          r.duration = e.duration;
          r.payload  = e.payload;
          if (op == OP_DEQ) begin
            void'(queue_shadow.pop_front());
          end
        end
      end
      OP_CLEAR: begin
        queue_shadow.delete();
      end
      OP_PROMOTE: begin
        // stable split: matching kind first, both groups keep their order
        foreach (queue_shadow[i]) begin
          if (queue_shadow[i].kind == kind) begin
            sum += longint'(queue_shadow[i].duration);
            match_q.push_back(queue_shadow[i]);
          end else begin
            other_q.push_back(queue_shadow[i]);
          end
        end
        queue_shadow = {match_q, other_q};
        if (sum > longint'(TOTAL_MAX)) sum = longint'(TOTAL_MAX);
        if (sum < longint'(TOTAL_MIN)) sum = longint'(TOTAL_MIN);
        r.total = sum[TOTAL_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [KIND_W-1:0] kind,
                                  input logic signed [DUR_W-1:0] dur,
                                  input logic [PAY_W-1:0] pay, input int reps,
                                  input bit typed, input status_e st,
                                  input logic signed [TOTAL_W-1:0] tot);
    dir_row_t row;
    row.op         = op;
    row.kind       = kind;
    row.dur        = dur;
    row.pay        = pay;
    row.reps       = reps;
    row.typed      = typed;
    row.exp_status = st;
    row.exp_total  = tot;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    return kind_pool[$urandom_range(0, 3)];
  endfunction

  // durations lean toward the signed extremes
  function automatic logic signed [DUR_W-1:0] pick_dur();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'(signed'($urandom_range(0, 8)) - 4);
      default: return $urandom();
    endcase
  endfunction

  // sender bursts with random gaps in between
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // present one item, wait for it to be taken, record what it should produce
  task automatic issue_op(input logic [2:0] op, input logic [KIND_W-1:0] kind,
                          input logic signed [DUR_W-1:0] dur, input logic [PAY_W-1:0] pay,
                          input bit typed, input queue_result_t typed_res);
    queue_result_t r;
    pace_sender();
    in_valid_i <= 1'b1;
    op_i       <= op;
    kind_i     <= kind;
    duration_i <= dur;
    payload_i  <= pay;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = apply_queue_op(op, kind, dur, pay);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  task automatic send(input logic [2:0] op, input logic [KIND_W-1:0] kind,
                      input logic signed [DUR_W-1:0] dur, input logic [PAY_W-1:0] pay);
    issue_op(op, kind, dur, pay, 1'b0, blank_res);
    if (op <= OP_PROMOTE) rand_items++;
  endtask

  // receiver stall pattern: switches at random among never, rare, frequent and periodic stalls
  initial begin
    int mode;
    int span;
    int cyc;
    out_stall_i = 1'b0;
    cyc = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk_i);
        cyc++;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ((cyc % 5) < 2);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending: status %0d total %0d", status_o, total_o);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_count++;
        end
        if (out_kind_o !== want.kind) begin
          $error("out_kind: expected %0h, got %0h", want.kind, out_kind_o);
          err_count++;
        end
        if (out_duration_o !== want.duration) begin
          $error("out_duration: expected %0d, got %0d", want.duration, out_duration_o);
          err_count++;
        end
        if (out_payload_o !== want.payload) begin
          $error("out_payload: expected %0h, got %0h", want.payload, out_payload_o);
          err_count++;
        end
        if (total_o !== want.total) begin
          $error("total: expected %0d, got %0d", want.total, total_o);
          err_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    queue_result_t want;
    logic [KIND_W-1:0] k;
    logic signed [DUR_W-1:0] d;
    int scen;
    int n;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = OP_ENQ;
    kind_i      = '0;
    duration_i  = '0;
    payload_i   = '0;
    err_count   = 0;
    rand_items  = 0;
    burst_left  = 0;
    blank_res.status   = STAT_OK;
    blank_res.kind     = '0;
    blank_res.duration = '0;
    blank_res.payload  = '0;
    blank_res.total    = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table: empty queue, ignored ops, extremes, full queue, saturated total
    add_row(OP_DEQ,      8'h00, 32'sh0,         32'h0,         1, 1, STAT_EMPTY, '0);
    add_row(OP_PEEK,     8'hFF, 32'sh0,         32'h0,         1, 1, STAT_EMPTY, '0);
    add_row(OP_PROMOTE,  8'h00, 32'sh0,         32'h0,         1, 1, STAT_OK,    '0);
    add_row(OP_SPARE_HI, 8'hFF, 32'shFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, STAT_OK,    '0);
    add_row(OP_ENQ,      8'hFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, STAT_OK,    '0);
    add_row(OP_ENQ,      8'h00, 32'sh8000_0000, 32'h0000_0000, 1, 1, STAT_OK,    '0);
    add_row(OP_PEEK,     8'h00, 32'sh0,         32'h0,         1, 0, STAT_OK,    '0);
    add_row(OP_PROMOTE,  8'h00, 32'sh0,         32'h0,         1, 0, STAT_OK,    '0);
    add_row(OP_DEQ,      8'h00, 32'sh0,         32'h0,         1, 0, STAT_OK,    '0);
    add_row(OP_PROMOTE,  8'h33, 32'sh0,         32'h0,         1, 1, STAT_OK,    '0);
    add_row(OP_CLEAR,    8'h00, 32'sh0,         32'h0,         1, 1, STAT_OK,    '0);
    add_row(OP_ENQ,      8'h80, 32'sh7FFF_FFFF, 32'hA5A5_0000, DEPTH, 1, STAT_OK, '0);
    add_row(OP_ENQ,      8'h80, 32'sh7FFF_FFFF, 32'h5A5A_5A5A, 1, 1, STAT_FULL,  '0);
    add_row(OP_PROMOTE,  8'h80, 32'sh0,         32'h0,         1, 1, STAT_OK,    TOTAL_MAX);
    add_row(OP_PEEK,     8'h00, 32'sh0,         32'h0,         1, 0, STAT_OK,    '0);

    foreach (dir_rows[i]) begin
      for (int r = 0; r < dir_rows[i].reps; r++) begin
        want          = blank_res;
        want.status   = dir_rows[i].exp_status;
        want.total    = dir_rows[i].exp_total;
        issue_op(dir_rows[i].op, dir_rows[i].kind, dir_rows[i].dur,
                 dir_rows[i].pay + PAY_W'(r), dir_rows[i].typed, want);
      end
    end

    // random part: mostly well-formed work with a small kind pool, some noise
    while (rand_items < RANDOM_ITEMS) begin
      for (int i = 0; i < 4; i++) begin
        kind_pool[i] = KIND_W'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 3) == 0) kind_pool[0] = 8'h00;
      if ($urandom_range(0, 3) == 0) kind_pool[1] = 8'hFF;
      scen = $urandom_range(0, 9);
      case (scen)
        // fill to the brim, overflow, then reorder and take a few
        5, 6: begin
          while (queue_shadow.size() < DEPTH) send(OP_ENQ, pick_kind(), pick_dur(), $urandom());
          repeat ($urandom_range(1, 3)) send(OP_ENQ, pick_kind(), pick_dur(), $urandom());
          repeat ($urandom_range(1, 3)) send(OP_PROMOTE, pick_kind(), $urandom(), $urandom());
          repeat ($urandom_range(0, 5)) begin
            send(OP_DEQ, KIND_W'($urandom()), $urandom(), $urandom());
          end
        end
        // full queue of one kind, durations all at one extreme or picked at random
        7: begin
          send(OP_CLEAR, KIND_W'($urandom()), $urandom(), $urandom());
          k = pick_kind();
          n = $urandom_range(0, 2);
          repeat (DEPTH) begin
            d = (n == 0) ? 32'sh7FFF_FFFF : (n == 1) ? 32'sh8000_0000 : pick_dur();
            send(OP_ENQ, k, d, $urandom());
          end
          send(OP_PROMOTE, k, $urandom(), $urandom());
          send(OP_PEEK, KIND_W'($urandom()), $urandom(), $urandom());
        end
        // drain past empty
        8: begin
          while (queue_shadow.size() > 0) begin
            send(OP_DEQ, KIND_W'($urandom()), $urandom(), $urandom());
          end
          repeat ($urandom_range(1, 2)) begin
            send($urandom_range(0, 1) ? OP_DEQ : OP_PEEK, KIND_W'($urandom()),
                 $urandom(), $urandom());
          end
          send(OP_PROMOTE, pick_kind(), $urandom(), $urandom());
        end
        // noise: any op code, full-range fields
        9: begin
          repeat ($urandom_range(5, 15)) begin
            send(3'($urandom_range(0, 7)), KIND_W'($urandom()), $urandom(), $urandom());
          end
        end
        // weighted mix of regular ops, with the odd spare op code
        default: begin
          repeat ($urandom_range(10, 30)) begin
            n = $urandom_range(0, 99);
            if (n < 45)      send(OP_ENQ, pick_kind(), pick_dur(), $urandom());
            else if (n < 65) send(OP_DEQ, KIND_W'($urandom()), $urandom(), $urandom());
            else if (n < 75) send(OP_PEEK, KIND_W'($urandom()), $urandom(), $urandom());
            else if (n < 95) send(OP_PROMOTE, pick_kind(), $urandom(), $urandom());
            else if (n < 98) send(OP_CLEAR, KIND_W'($urandom()), $urandom(), $urandom());
            else             send(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                                  KIND_W'($urandom()), $urandom(), $urandom());
          end
        end
      endcase
    end

    // wind down and let any stray result show up
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/qwkp_pkg.sv
rtl/qwkp_ram.sv
rtl/qwkp_acc.sv
rtl/queue_with_kind_promote_unit.sv
tb/queue_with_kind_promote_unit_tb.sv
